// ----- rtl/joint_bilateral_depth_filter_top_defines.svh -----
// assertion macros for the joint bilateral depth filter
`ifndef JOINT_BILATERAL_DEPTH_FILTER_TOP_DEFINES_SVH
`define JOINT_BILATERAL_DEPTH_FILTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// condition must never hold outside reset
`define JBDF_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("jbdf assertion failed");
// antecedent implies consequent in the same cycle
`define JBDF_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jbdf assertion failed");
`else
`define JBDF_NEVER(lbl, cond)
`define JBDF_IMPLIES(lbl, ante, cons)
`endif
`endif

// ----- rtl/jbdf_pkg.sv -----
package jbdf_pkg;

    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int DIM_W      = 13;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;
    localparam int TOTAL_W    = 25;
    localparam int POS_W      = 27;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;
    localparam int HEIGHT_MAX = 2048;
    localparam int TW_FIELD   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [1:0] REQ_PIXEL   = 2'd0;
    localparam logic [1:0] REQ_RANGE   = 2'd1;
    localparam logic [1:0] REQ_SPATIAL = 2'd2;
    localparam logic [1:0] REQ_DRAIN   = 2'd3;

    typedef enum logic [1:0] {
        K_RANGE   = 2'd0,
        K_SPATIAL = 2'd1,
        K_SHIFT   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [7:0]          guide_pixel;
        logic [7:0]          depth_pixel;
        logic [7:0]          table_index;
        logic [TW_FIELD-1:0] table_weight;
    } t_in;

    typedef struct packed {
        logic [7:0] filtered_depth;
        logic       is_border;
        logic       frame_last;
    } t_out;

    // decoded work handed from front to back
    typedef struct packed {
        t_kind               kind;
        logic                want_out;
        logic                is_border;
        logic                frame_last;
        logic [7:0]          index;
        logic [TW_FIELD-1:0] weight;
        logic [7:0]          guide;
        logic [7:0]          depth;
        logic [COL_W-1:0]    col;
    } t_item;

endpackage

// ----- rtl/jbdf_ram.sv -----
module jbdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/jbdf_fifo.sv -----
module jbdf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

endmodule

// ----- rtl/jbdf_front.sv -----
module jbdf_front #(
    parameter int WINDOW    = 5,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  jbdf_pkg::t_in                  i_in,
    input  logic                           i_cfg_we,
    input  logic [jbdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jbdf_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                           o_push,
    output jbdf_pkg::t_item                o_item
);

    localparam int HALF  = WINDOW / 2;
    localparam int TAPS  = 2 * HALF + 1;
    localparam int NT    = TAPS * TAPS;
    localparam int DW    = jbdf_pkg::DIM_W;
    localparam int PW    = jbdf_pkg::POS_W;

    logic [jbdf_pkg::CFG_W-1:0]   r_cfg_w, r_cfg_h;
    logic [jbdf_pkg::COL_W-1:0]   r_col, n_col;
    logic [jbdf_pkg::ROW_W-1:0]   r_row, n_row;
    logic [jbdf_pkg::TOTAL_W-1:0] w_total;
    logic [DW-1:0]                w_w, w_h, w_rc, w_cc, w_col_e;
    logic [PW-1:0]                w_pos, w_doff;
    logic signed [PW-1:0]         w_q, w_tot;
    logic                         w_in_frame, w_want, w_border, w_last, w_wrap, w_lo;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_w = DW'(1);
        end else if (DW'(r_cfg_w) > DW'(MAX_WIDTH)) begin
            w_w = DW'(MAX_WIDTH);
        end else begin
            w_w = DW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            w_h = DW'(1);
        end else if (DW'(r_cfg_h) > DW'(jbdf_pkg::HEIGHT_MAX)) begin
            w_h = DW'(jbdf_pkg::HEIGHT_MAX);
        end else begin
            w_h = DW'(r_cfg_h);
        end
        // frame size follows a register write at once
        w_total = jbdf_pkg::TOTAL_W'(w_w) * jbdf_pkg::TOTAL_W'(w_h);
    end

    // delayed position relative to the frame origin
    always_comb begin
        w_col_e    = DW'(r_col);
        w_pos      = PW'(r_row) * PW'(w_w) + PW'(r_col);
        w_doff     = PW'(HALF) * PW'(w_w) + PW'(HALF);
        w_q        = $signed(w_pos - w_doff);
        w_tot      = $signed(PW'(w_total));
        w_in_frame = DW'(r_row) < w_h;
        w_want     = (w_q >= 0) && (w_q < w_tot);
        w_last     = (w_q == w_tot - 1);
        w_wrap     = (w_q >= w_tot - 1);
        w_lo       = w_col_e < DW'(HALF);
        w_rc       = DW'(r_row) - DW'(HALF) - DW'(w_lo);
        w_cc       = w_lo ? (w_col_e + w_w - DW'(HALF)) : (w_col_e - DW'(HALF));
        w_border   = (w_w <= DW'(HALF)) || (w_rc < DW'(HALF)) || (w_rc + DW'(HALF) >= w_h)
                     || (w_cc < DW'(HALF)) || (w_cc + DW'(HALF) >= w_w);
    end

    always_comb begin
        o_push          = 1'b0;
        o_item.kind     = jbdf_pkg::K_SHIFT;
        o_item.want_out = w_want;
        o_item.is_border = w_border;
        o_item.frame_last = w_last;
        o_item.index    = i_in.table_index;
        o_item.weight   = i_in.table_weight;
        o_item.guide    = '0;
        o_item.depth    = '0;
        o_item.col      = r_col;
        n_col           = r_col;
        n_row           = r_row;
        case (i_in.req_type)
            jbdf_pkg::REQ_RANGE: begin
                o_item.kind = jbdf_pkg::K_RANGE;
                o_push      = i_accept;
            end
            jbdf_pkg::REQ_SPATIAL: begin
                o_item.kind = jbdf_pkg::K_SPATIAL;
                o_push      = i_accept && (i_in.table_index < 8'(NT));
            end
            default: begin
                if (!(i_in.req_type == jbdf_pkg::REQ_DRAIN && w_in_frame)) begin
                    o_push = i_accept;
                    if (i_in.req_type == jbdf_pkg::REQ_PIXEL && w_in_frame) begin
                        o_item.guide = i_in.guide_pixel;
                        o_item.depth = i_in.depth_pixel;
                    end
                    if (w_wrap) begin
                        n_col = '0;
                        n_row = '0;
                    end else if (w_col_e + DW'(1) >= w_w) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= jbdf_pkg::CFG_W'(jbdf_pkg::WIDTH_RST);
            r_cfg_h <= jbdf_pkg::CFG_W'(jbdf_pkg::HEIGHT_RST);
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == jbdf_pkg::CFG_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == jbdf_pkg::CFG_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
            if (o_push) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

// ----- rtl/jbdf_back.sv -----
module jbdf_back #(
    parameter int WINDOW      = 5,
    parameter int MAX_WIDTH   = 2048,
    parameter int WEIGHT_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  jbdf_pkg::t_item i_item,
    output logic            o_pop,
    input  logic            i_res_full,
    output logic            o_res_push,
    output jbdf_pkg::t_out  o_res
);

    localparam int HALF   = WINDOW / 2;
    localparam int TAPS   = 2 * HALF + 1;
    localparam int NT     = TAPS * TAPS;
    localparam int LINES  = 2 * HALF;
    localparam int CENTER = HALF * TAPS + HALF;
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int TW     = $clog2(NT);
    localparam int EWB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int PW     = 2 * EWB;
    localparam int SW     = PW + TW;
    localparam int SWD    = SW + 8;
    localparam int LW     = 16 * LINES;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_TAP   = 6'b000100,
        S_FLUSH = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    jbdf_pkg::t_item r_item;
    logic [7:0]      r_gwin [NT];
    logic [7:0]      r_dwin [NT];
    logic [TW-1:0]   r_t;
    logic            r_vb, r_vc, r_vd, r_centre;
    logic [7:0]      r_db, r_dc, r_q;
    logic [PW-1:0]   r_wc;
    logic [PW+7:0]   r_wdd;
    logic [SW-1:0]   r_sw;
    logic [SWD-1:0]  r_swd, r_rem;
    logic [2:0]      r_i;

    logic            w_rng_we, w_spa_we, w_line_we;
    logic [EWB-1:0]  w_wmask, w_rng_rd, w_spa_rd;
    logic [7:0]      w_gc, w_gt, w_diff;
    logic [LW-1:0]   w_line_rd, w_line_wd;
    logic [7:0]      w_gv [TAPS];
    logic [7:0]      w_dv [TAPS];
    logic [SWD-1:0]  w_cand;

    assign w_wmask = EWB'(i_item.weight);
    assign w_gc    = r_gwin[CENTER];
    assign w_gt    = r_gwin[r_t];
    assign w_diff  = (w_gc > w_gt) ? (w_gc - w_gt) : (w_gt - w_gc);
    assign o_pop   = (r_state == S_IDLE) && i_valid;
    assign w_rng_we = o_pop && (i_item.kind == jbdf_pkg::K_RANGE);
    assign w_spa_we = o_pop && (i_item.kind == jbdf_pkg::K_SPATIAL);
    assign w_line_we = (r_state == S_SHIFT);

    jbdf_ram #(.WIDTH(EWB), .DEPTH(256)) u_range (
        .i_clk  (i_clk),
        .i_we   (w_rng_we),
        .i_waddr(i_item.index),
        .i_wdata(w_wmask),
        .i_raddr(w_diff),
        .o_rdata(w_rng_rd)
    );

    jbdf_ram #(.WIDTH(EWB), .DEPTH(NT)) u_spatial (
        .i_clk  (i_clk),
        .i_we   (w_spa_we),
        .i_waddr(i_item.index[TW-1:0]),
        .i_wdata(w_wmask),
        .i_raddr(r_t),
        .o_rdata(w_spa_rd)
    );

    // per column: guide bytes low, depth bytes high, oldest line in byte 0
    jbdf_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
        .i_clk  (i_clk),
        .i_we   (w_line_we),
        .i_waddr(r_item.col[AW-1:0]),
        .i_wdata(w_line_wd),
        .i_raddr(i_item.col[AW-1:0]),
        .o_rdata(w_line_rd)
    );

    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            w_gv[k] = w_line_rd[8*k +: 8];
            w_dv[k] = w_line_rd[8*LINES + 8*k +: 8];
        end
        w_gv[LINES] = r_item.guide;
        w_dv[LINES] = r_item.depth;
        for (int k = 0; k < LINES; k++) begin
            w_line_wd[8*k +: 8]          = w_gv[k+1];
            w_line_wd[8*LINES + 8*k +: 8] = w_dv[k+1];
        end
    end

    assign w_cand = SWD'(r_sw) << r_i;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_item.kind == jbdf_pkg::K_SHIFT) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (!r_item.want_out) begin
                    n_state = S_IDLE;
                end else if (r_item.is_border) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_TAP;
                end
            end
            S_TAP: begin
                if (r_t == TW'(NT-1)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_vb && !r_vc && !r_vd) begin
                    n_state = (r_sw == '0) ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                if (r_i == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_vd    <= 1'b0;
            for (int n = 0; n < NT; n++) begin
                r_gwin[n] <= '0;
                r_dwin[n] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_vb    <= (r_state == S_TAP);
            r_vc    <= r_vb;
            r_vd    <= r_vc;
            if (r_state == S_SHIFT) begin
                for (int a = 0; a < TAPS; a++) begin
                    for (int b = 0; b < TAPS - 1; b++) begin
                        r_gwin[a*TAPS+b] <= r_gwin[a*TAPS+b+1];
                        r_dwin[a*TAPS+b] <= r_dwin[a*TAPS+b+1];
                    end
                    r_gwin[a*TAPS+TAPS-1] <= w_gv[a];
                    r_dwin[a*TAPS+TAPS-1] <= w_dv[a];
                end
            end
        end
    end

    // tap-serial multiply-accumulate, then restoring divide for 8 quotient bits
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == S_SHIFT) begin
            r_t      <= '0;
            r_sw     <= '0;
            r_swd    <= '0;
            r_centre <= 1'b1;
        end
        if (r_state == S_TAP) begin
            r_t  <= r_t + 1'b1;
            r_db <= r_dwin[r_t];
        end
        if (r_vb) begin
            r_wc <= PW'(w_rng_rd) * PW'(w_spa_rd);
            r_dc <= r_db;
        end
        if (r_vc) begin
            r_sw  <= r_sw + SW'(r_wc);
            r_wdd <= (PW+8)'(r_wc) * (PW+8)'(r_dc);
        end
        if (r_vd) begin
            r_swd <= r_swd + SWD'(r_wdd);
        end
        if (r_state == S_FLUSH) begin
            r_rem    <= r_swd;
            r_i      <= 3'd7;
            r_q      <= '0;
            r_centre <= (r_sw == '0);
        end
        if (r_state == S_DIV) begin
            if (r_rem >= w_cand) begin
                r_rem    <= r_rem - w_cand;
                r_q[r_i] <= 1'b1;
            end
            r_i <= r_i - 1'b1;
        end
    end

    assign o_res_push           = (r_state == S_OUT) && !i_res_full;
    assign o_res.filtered_depth = r_centre ? r_dwin[CENTER] : r_q;
    assign o_res.is_border      = r_item.is_border;
    assign o_res.frame_last     = r_item.frame_last;

endmodule

// ----- rtl/joint_bilateral_depth_filter_top.sv -----
// Joint bilateral depth filter: guide and depth pixels stream in raster order and each
// pixel beat yields, once the window has filled, the filtered depth of the pixel half a
// window up and to the left; drain beats after the last pixel flush out the remaining
// results, and range and spatial weight table loads travel on the same input queue.
// A front end decodes each word, tracks the raster position and marks border pixels;
// a back end works one word at a time behind a four-entry queue. A table load only
// writes its table, a pixel with no result only shifts the window, a border pixel
// also gives its centre depth, and a filtered pixel passes through the single
// multiply-accumulate that walks the taps, its drain and the 8-step divider behind it;
// the divider is skipped when the weight sum is zero and the centre depth comes out.
// Nothing needs clearing after reset: line buffers and tables must be written before use.
`include "joint_bilateral_depth_filter_top_defines.svh"

module joint_bilateral_depth_filter_top #(
    parameter int WINDOW      = 5,
    parameter int MAX_WIDTH   = 2048,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input word queue
    input  logic                           push,
    output logic                           full,
    input  jbdf_pkg::t_in                  i_in_item,
    // result word queue
    output logic                           empty,
    input  logic                           pop,
    output jbdf_pkg::t_out                 o_out_item,
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [jbdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jbdf_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int IW = $bits(jbdf_pkg::t_item);
    localparam int OW = $bits(jbdf_pkg::t_out);

    jbdf_pkg::t_item w_f_item, w_b_item;
    jbdf_pkg::t_out  w_res;
    logic            w_accept, w_q_push, w_q_full, w_q_empty, w_q_pop;
    logic            w_res_push, w_res_full;
    logic [IW-1:0]   w_q_rd;
    logic [OW-1:0]   w_o_rd;

    // registers always take a write
    assign o_cfg_ready = 1'b1;
    assign full        = w_q_full;
    assign w_accept    = push && !w_q_full;

    // front end: decode, raster position, border marking
    jbdf_front #(.WINDOW(WINDOW), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_in       (i_in_item),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_push     (w_q_push),
        .o_item     (w_f_item)
    );

    // decoupling queue between front and back
    jbdf_fifo #(.WIDTH(IW), .DEPTH(4)) u_work_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_data (w_f_item),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_data (w_q_rd),
        .o_empty(w_q_empty)
    );

    assign w_b_item = jbdf_pkg::t_item'(w_q_rd);

    // back end: line buffers, window, weighting and divide
    jbdf_back #(.WINDOW(WINDOW), .MAX_WIDTH(MAX_WIDTH), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!w_q_empty),
        .i_item    (w_b_item),
        .o_pop     (w_q_pop),
        .i_res_full(w_res_full),
        .o_res_push(w_res_push),
        .o_res     (w_res)
    );

    // result queue decouples the back end from the consumer
    jbdf_fifo #(.WIDTH(OW), .DEPTH(2)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_o_rd),
        .o_empty(empty)
    );

    assign o_out_item = jbdf_pkg::t_out'(w_o_rd);

    // back end never pushes a result into a full result queue
    `JBDF_NEVER(a_res_overflow, w_res_push && w_res_full)
    // front end never enqueues into a full work queue
    `JBDF_NEVER(a_work_overflow, w_q_push && w_q_full)
    // work is enqueued only for an accepted input word
    `JBDF_IMPLIES(a_push_source, w_q_push, push && !full)

endmodule

// ----- sim/jbdf_checker.sv -----
// watches the input, result and register channels of the depth filter,
// predicts each result word and compares it with what the block gives
module jbdf_checker
    import jbdf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  t_in                  i_in_item,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  t_out                 i_out_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_result_count,
    output int                   o_filtered_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF  = 2;
    localparam int TAPS  = 2 * HALF + 1;
    localparam int LINES = 2 * HALF;
    localparam int MAXW  = 2048;

    logic [7:0]  guide_line [0:LINES*MAXW-1];
    logic [7:0]  depth_line [0:LINES*MAXW-1];
    logic [7:0]  guide_win  [0:TAPS-1][0:TAPS-1];
    logic [7:0]  depth_win  [0:TAPS-1][0:TAPS-1];
    logic [15:0] range_wt   [0:255];
    logic [15:0] spatial_wt [0:TAPS*TAPS-1];
    logic [CFG_W-1:0] width_reg, height_reg;
    int unsigned col_pos, row_pos;
    t_out expected_q[$];
    int fails, results, filtered;

    assign o_fail_count     = fails;
    assign o_pending        = expected_q.size();
    assign o_result_count   = results;
    assign o_filtered_count = filtered;

    initial begin
        fails    = 0;
        results  = 0;
        filtered = 0;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAXW) return MAXW;
        return v;
    endfunction

    // push one column of guide and depth into the window, oldest line on top
    function automatic void shift_column(input logic [7:0] g, input logic [7:0] d);
        logic [7:0] gcol [0:TAPS-1];
        logic [7:0] dcol [0:TAPS-1];
        int unsigned c, slot;
        c = col_pos % MAXW;
        for (int k = 0; k < LINES; k++) begin
            slot = (row_pos + k) % LINES;
            gcol[k] = guide_line[slot*MAXW + c];
            dcol[k] = depth_line[slot*MAXW + c];
        end
        gcol[LINES] = g;
        dcol[LINES] = d;
        guide_line[(row_pos % LINES)*MAXW + c] = g;
        depth_line[(row_pos % LINES)*MAXW + c] = d;
        for (int k = 0; k < TAPS; k++) begin
            for (int j = 0; j < TAPS - 1; j++) begin
                guide_win[k][j] = guide_win[k][j+1];
                depth_win[k][j] = depth_win[k][j+1];
            end
            guide_win[k][TAPS-1] = gcol[k];
            depth_win[k][TAPS-1] = dcol[k];
        end
    endfunction

    function automatic logic [7:0] weighted_depth();
        longint unsigned sum_w, sum_wd, wt;
        logic [7:0] gc, gt, diff;
        sum_w  = 0;
        sum_wd = 0;
        gc = guide_win[HALF][HALF];
        for (int a = 0; a < TAPS; a++) begin
            for (int b = 0; b < TAPS; b++) begin
                gt   = guide_win[a][b];
                diff = (gc > gt) ? gc - gt : gt - gc;
                wt   = longint'(range_wt[diff]) * longint'(spatial_wt[a*TAPS + b]);
                sum_w  += wt;
                sum_wd += wt * depth_win[a][b];
            end
        end
        if (sum_w == 0) return depth_win[HALF][HALF];
        return 8'(sum_wd / sum_w);
    endfunction

    function automatic void predict_word(input t_in w);
        int unsigned wd, ht, rc, cc;
        longint q, total;
        logic [7:0] g, d;
        t_out r;
        if (w.req_type == REQ_RANGE) begin
            range_wt[w.table_index] = w.table_weight;
            return;
        end
        if (w.req_type == REQ_SPATIAL) begin
            if (w.table_index < TAPS*TAPS) spatial_wt[w.table_index] = w.table_weight;
            return;
        end
        wd = clamp_dim(width_reg);
        ht = clamp_dim(height_reg);
        // drain beats are ignored until every pixel of the frame is in
        if (w.req_type == REQ_DRAIN && row_pos < ht) return;
        g = 0;
        d = 0;
        if (w.req_type == REQ_PIXEL && row_pos < ht) begin
            g = w.guide_pixel;
            d = w.depth_pixel;
        end
        shift_column(g, d);
        q     = longint'(row_pos) * wd + col_pos - (longint'(HALF) * wd + HALF);
        total = longint'(wd) * ht;
        if (q >= 0 && q < total) begin
            rc = q / wd;
            cc = q % wd;
            r.is_border = (rc < HALF) || (rc + HALF >= ht) || (cc < HALF) || (cc + HALF >= wd);
            r.filtered_depth = r.is_border ? depth_win[HALF][HALF] : weighted_depth();
            r.frame_last = (q == total - 1);
            expected_q.push_back(r);
        end
        if (q >= total - 1) begin
            col_pos = 0;
            row_pos = 0;
        end else if (col_pos + 1 >= wd) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
    endfunction

    task automatic report(input string field, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            width_reg  <= CFG_W'(WIDTH_RST);
            height_reg <= CFG_W'(HEIGHT_RST);
            col_pos    = 0;
            row_pos    = 0;
            for (int a = 0; a < TAPS; a++) begin
                for (int b = 0; b < TAPS; b++) begin
                    guide_win[a][b] = 0;
                    depth_win[a][b] = 0;
                end
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH) width_reg <= i_cfg_data;
                else if (i_cfg_index == CFG_HEIGHT) height_reg <= i_cfg_data;
            end
            if (i_push && !i_full) predict_word(i_in_item);
            if (i_pop && !i_empty) begin
                results++;
                if (expected_q.size() == 0) begin
                    $display("[%0t] result word with nothing expected", $realtime);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (!want.is_border) filtered++;
                    if (i_out_item.filtered_depth !== want.filtered_depth)
                        report("filtered_depth", i_out_item.filtered_depth, want.filtered_depth);
                    if (i_out_item.is_border !== want.is_border)
                        report("is_border", i_out_item.is_border, want.is_border);
                    if (i_out_item.frame_last !== want.frame_last)
                        report("frame_last", i_out_item.frame_last, want.frame_last);
                end
            end
        end
    end

endmodule

// ----- sim/joint_bilateral_depth_filter_top_tb.sv -----
// stimulus and verdict for the joint bilateral depth filter
module joint_bilateral_depth_filter_top_tb;
    import jbdf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no word moving on any channel before the run is called hung
    localparam int STALL_LIMIT = 5000;
    // quiet time before a register write, covers words still in the back end
    localparam int SETTLE_CYCLES = 250;
    localparam int RANDOM_WORDS = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    t_in  in_word = '0;
    logic empty;
    logic pop = 1'b0;
    t_out out_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;

    int fail_count, pending, result_count, filtered_count;
    int tx_idle = 17;
    int rx_idle = 62;
    int sent = 0;
    int random_sent = 0;
    int frames = 0;
    int quiet_cycles = 0;
    bit in_random = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    joint_bilateral_depth_filter_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    jbdf_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_in_item        (in_word),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_out_item       (out_word),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_result_count   (result_count),
        .o_filtered_count (filtered_count)
    );

    // result side: random back-pressure at the current idle rate
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= rx_idle);
    end

    // watchdog on channel activity
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > 2048) return 2048;
        return v;
    endfunction

    // all fields random, then the kind forced; unused fields still toggle
    function automatic t_in random_word(input logic [1:0] kind);
        t_in w;
        w = t_in'({$urandom, $urandom});
        w.req_type = kind;
        return w;
    endfunction

    function automatic t_in table_word();
        t_in w;
        if ($urandom_range(1)) begin
            w = random_word(REQ_RANGE);
        end else begin
            w = random_word(REQ_SPATIAL);
            // mostly valid taps, sometimes out of range and ignored
            if ($urandom_range(9) < 8) w.table_index = 8'($urandom_range(24));
        end
        return w;
    endfunction

    function automatic t_in pixel_word(input bit extremes);
        t_in w;
        w = random_word(REQ_PIXEL);
        if (extremes) begin
            w.guide_pixel = $urandom_range(1) ? 8'hFF : 8'h00;
            w.depth_pixel = $urandom_range(1) ? 8'hFF : 8'h00;
        end else if ($urandom_range(1)) begin
            // flat-ish guide so range weights spread across many taps
            w.guide_pixel = 8'($urandom_range(120, 136));
        end
        return w;
    endfunction

    // idle rates follow the progress of the random part
    function automatic void update_idle();
        if (!in_random || random_sent < RANDOM_WORDS/3) begin
            tx_idle = 17;
            rx_idle = 62;
        end else if (random_sent < 2*RANDOM_WORDS/3) begin
            tx_idle = 62;
            rx_idle = 17;
        end else begin
            tx_idle = 0;
            rx_idle = 0;
        end
    endfunction

    task automatic send(input t_in w);
        update_idle();
        while ($urandom_range(99) < tx_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent++;
        if (in_random) random_sent++;
    endtask

    // hold the input until every expected word is out, then let the back end empty
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dims(input logic [CFG_W-1:0] wr, input logic [CFG_W-1:0] hr);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= wr;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= hr;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // one whole frame: pixels, then drain beats until the last result is due
    task automatic run_frame(input logic [CFG_W-1:0] wr, input logic [CFG_W-1:0] hr,
                             input bit extremes, input bit pause_mid);
        int unsigned ew, eh, total;
        settle();
        write_dims(wr, hr);
        ew = clamp_dim(wr);
        eh = clamp_dim(hr);
        total = ew * eh;
        for (int unsigned p = 0; p < total; p++) begin
            if ($urandom_range(99) < 4) send(table_word());
            // drain beat before the frame is complete does nothing
            if ($urandom_range(99) < 3) send(random_word(REQ_DRAIN));
            if (pause_mid && p == total/2) begin
                push <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            send(pixel_word(extremes));
        end
        for (int unsigned i = 0; i < 2*ew + 2; i++) begin
            if ($urandom_range(99) < 3) send(table_word());
            // a pixel beat while draining acts as a drain beat
            send(random_word($urandom_range(99) < 20 ? REQ_PIXEL : REQ_DRAIN));
        end
        frames++;
    endtask

    task automatic load_tables(input bit spatial_zero);
        t_in w;
        for (int i = 0; i < 25; i++) begin
            w = random_word(REQ_SPATIAL);
            w.table_index = 8'(i);
            if (spatial_zero) w.table_weight = '0;
            else if (i == 12) w.table_weight = 16'hFFFF;
            else if (w.table_weight == 0) w.table_weight = 16'h0001;
            send(w);
        end
    endtask

    initial begin
        t_in w;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every range entry defined, extremes of weight and index
        for (int i = 0; i < 256; i++) begin
            w = random_word(REQ_RANGE);
            w.table_index = 8'(i);
            if (i == 0) w.table_weight = 16'hFFFF;
            else if (i == 255 || $urandom_range(9) == 0) w.table_weight = '0;
            send(w);
        end
        load_tables(1'b0);
        // spatial indexes past the last tap are ignored
        w = random_word(REQ_SPATIAL);
        w.table_index = 8'd25;
        send(w);
        w.table_index = 8'd255;
        send(w);
        // drain beat with no frame in flight
        send(random_word(REQ_DRAIN));
        run_frame(12'd5, 12'd5, 1'b1, 1'b0);
        // zero spatial kernel gives a zero weight sum: centre depth comes out
        load_tables(1'b1);
        run_frame(12'd6, 12'd5, 1'b0, 1'b0);
        load_tables(1'b0);
        // zero register values act as one
        run_frame(12'd0, 12'd0, 1'b0, 1'b0);

        // random frames, mostly small
        in_random = 1'b1;
        while (random_sent < RANDOM_WORDS)
            run_frame(12'($urandom_range(1, 14)), 12'($urandom_range(1, 9)), 1'b0,
                      frames == 3);

        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d input words over %0d frames, %0d random", sent, frames,
                 random_sent);
        $display("checked %0d result words, %0d of them filtered", result_count,
                 filtered_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- joint_bilateral_depth_filter_top.f -----
+incdir+rtl
rtl/jbdf_pkg.sv
rtl/jbdf_ram.sv
rtl/jbdf_fifo.sv
rtl/jbdf_front.sv
rtl/jbdf_back.sv
rtl/joint_bilateral_depth_filter_top.sv
sim/jbdf_checker.sv
sim/joint_bilateral_depth_filter_top_tb.sv
